[design/tcsa_pkg.sv]
// Package: shared types and constants for the three-class slab allocator.
`timescale 1ns / 1ps
package tcsa_pkg;
  localparam int unsigned NumPagesDef    = 16;
  localparam int unsigned HeaderBytesDef = 48;
  localparam int unsigned PageBytes      = 4096;
  localparam int unsigned AddrPages      = 16;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSize  = 3'd1,
    StNoPage   = 3'd2,
    StNotSlab  = 3'd3,
    StRange    = 3'd4,
    StMisalign = 3'd5,
    StDouble   = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScan,
    SBitScan,
    SClaim,
    SRecRd,
    SRecUpd,
    SFreeRd,
    SFreeChk,
    SWrite,
    SOut
  } state_e;

  // Objects per page for a class: largest n up to 63 with hdr + n*sz + ceil(n/8) <= page.
  function automatic logic [5:0] objs_for(input int unsigned hdr, input int unsigned sz);
    int unsigned n;
    n = 63;
    while (n > 0 && hdr + n * sz + ((n + 7) >> 3) > PageBytes) n--;
    return 6'(n);
  endfunction
endpackage

[design/tcsa_ram.sv]
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module tcsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                           wdata_i,
  output logic [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[design/three_class_slab_allocator.sv]
// Top level of the three-class slab allocator.
`timescale 1ns / 1ps
// Three-class slab allocator over a pool of pages.
// Input channel s_axis_*: one request per handshake; tdata carries alloc_size
// (bits 11:0) and free_addr (27:12), tuser carries cmd (0 allocate, 1 free).
// Output channel m_axis_*: one result per request; tdata carries status (2:0),
// obj_addr (18:3), size_class (20:19), page_released (21).
// Per-page state (class, free count, bitmap, recency) sits in one synchronous
// RAM word per page; active flags are flip-flops cleared by reset.
// An allocation walks all P usable pages to find the newest page of its class
// with room, then searches that page's bitmap one bit a cycle.
// Claiming a page bumps the recency of its class in another walk over the
// pages; a retiring free walks the pages the same way to close the recency gap.
// One request is in flight at a time, and the next request is taken in the
// cycle after the result handshake.
// Reset clears all active flags and the controller; no clearing pass runs.
// When the receiver stalls, the result holds on m_axis and s_axis_tready
// stays low until the result is taken.
module three_class_slab_allocator #(
  parameter int unsigned NUM_PAGES    = tcsa_pkg::NumPagesDef,
  parameter int unsigned HEADER_BYTES = tcsa_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // alloc_size[11:0], free_addr[27:12]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, obj_addr, size_class, page_released
);
  import tcsa_pkg::*;

  localparam int unsigned Usable = (NUM_PAGES < AddrPages) ? NUM_PAGES : AddrPages;
  localparam int unsigned PW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW     = $clog2(Usable + 1);
  localparam int unsigned WW     = 2 + 6 + 63 + 4;
  localparam logic [5:0]  Objs0  = objs_for(HEADER_BYTES, 64);
  localparam logic [5:0]  Objs1  = objs_for(HEADER_BYTES, 128);
  localparam logic [5:0]  Objs2  = objs_for(HEADER_BYTES, 256);
  localparam logic [15:0] Hdr    = 16'(HEADER_BYTES);

  function automatic logic [5:0] objs_of(input logic [1:0] c);
    case (c)
      2'd0:    return Objs0;
      2'd1:    return Objs1;
      default: return Objs2;
    endcase
  endfunction

  state_e             state_q, state_d;
  logic [NUM_PAGES-1:0] act_q, act_d;
  logic               cmd_q, cmd_d;
  logic [15:0]        faddr_q, faddr_d;
  logic [1:0]         cls_q, cls_d;
  logic [CW-1:0]      pidx_q, pidx_d;
  logic               found_q, found_d;
  logic [PW-1:0]      best_q, best_d;
  logic [3:0]         brec_q, brec_d;
  logic [5:0]         bit_q, bit_d;
  logic [WW-1:0]      word_q, word_d;
  logic [3:0]         relrec_q, relrec_d;
  logic [2:0]         st_q, st_d;
  logic [15:0]        oaddr_q, oaddr_d;
  logic               rel_q, rel_d;

  logic               we;
  logic [PW-1:0]      ra;
  logic [WW-1:0]      wd, rd;

  tcsa_ram #(.Width(WW), .Depth(NUM_PAGES)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ra), .wdata_i(wd), .rdata_o(rd)
  );

  // RAM word: {class[74:73], free[72:67], bitmap[66:4], recency[3:0]}
  logic [1:0]  rd_cls;
  logic [5:0]  rd_free;
  logic [62:0] rd_bm;
  logic [3:0]  rd_rec;
  assign rd_cls  = rd[74:73];
  assign rd_free = rd[72:67];
  assign rd_bm   = rd[66:4];
  assign rd_rec  = rd[3:0];

  logic [PW-1:0] pcur;
  assign pcur = PW'(pidx_q);

  logic [11:0] fofs;
  logic [11:0] frel;
  logic [15:0] flim;
  logic [5:0]  fidx;
  logic        fmis;
  logic [3:0]  fpage;
  assign fpage = faddr_q[15:12];
  assign fofs  = faddr_q[11:0];
  assign frel  = fofs - Hdr[11:0];
  assign flim  = {10'd0, objs_of(rd_cls)} << (6 + rd_cls);
  always_comb begin
    case (rd_cls)
      2'd0:    begin fidx = frel[11:6];       fmis = |frel[5:0]; end
      2'd1:    begin fidx = {1'b0, frel[11:7]}; fmis = |frel[6:0]; end
      default: begin fidx = {2'b0, frel[11:8]}; fmis = |frel[7:0]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; faddr_q <= faddr_d; cls_q <= cls_d;
    pidx_q <= pidx_d; found_q <= found_d; best_q <= best_d; brec_q <= brec_d;
    bit_q <= bit_d; word_q <= word_d; relrec_q <= relrec_d;
    st_q <= st_d; oaddr_q <= oaddr_d; rel_q <= rel_d;
  end

  always_comb begin
    state_d = state_q; act_d = act_q; cmd_d = cmd_q;
    faddr_d = faddr_q; cls_d = cls_q; pidx_d = pidx_q; found_d = found_q;
    best_d = best_q; brec_d = brec_q; bit_d = bit_q; word_d = word_q;
    relrec_d = relrec_q; st_d = st_q; oaddr_d = oaddr_q; rel_d = rel_q;
    we = 1'b0; ra = pcur; wd = word_q;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser;
          faddr_d = s_axis_tdata[27:12];
          pidx_d  = '0;
          found_d = 1'b0;
          oaddr_d = '0;
          rel_d   = 1'b0;
          st_d    = StOk;
          if (s_axis_tuser == CmdFree) begin
            if (32'(s_axis_tdata[27:24]) >= Usable ||
                !act_q[PW'(s_axis_tdata[27:24])]) begin
              st_d = StNotSlab; cls_d = 2'd0; state_d = SOut;
            end else begin
              ra = PW'(s_axis_tdata[27:24]);
              state_d = SFreeChk;
            end
          end else if (s_axis_tdata[11:0] == 12'd0 || s_axis_tdata[11:0] > 12'd256) begin
            st_d = StBadSize; cls_d = 2'd0; state_d = SOut;
          end else begin
            cls_d = (s_axis_tdata[11:0] <= 12'd64) ? 2'd0 :
                    (s_axis_tdata[11:0] <= 12'd128) ? 2'd1 : 2'd2;
            state_d = SScanRd;
          end
        end
      end
      // Issue a read for page pidx, or finish the scan.
      SScanRd: begin
        if (32'(pidx_q) >= Usable) begin
          if (found_q) begin
            ra = best_q; bit_d = '0; state_d = SBitScan;
            pidx_d = '0;
          end else begin
            state_d = SClaim; pidx_d = '0;
          end
        end else begin
          ra = pcur; state_d = SScan;
        end
      end
      SScan: begin
        if (act_q[pcur] && rd_cls == cls_q && rd_free != 6'd0 &&
            (!found_q || rd_rec < brec_q)) begin
          found_d = 1'b1; best_d = pcur; brec_d = rd_rec;
        end
        pidx_d = pidx_q + 1'b1;
        state_d = SScanRd;
      end
      // RAM output holds best page's word (address held at best).
      SBitScan: begin
        ra = best_q;
        if (!rd_bm[bit_q]) begin
          word_d = {rd_cls, rd_free - 6'd1, rd_bm | (63'd1 << bit_q), rd_rec};
          oaddr_d = {4'(best_q), 12'd0} + Hdr + ({10'd0, bit_q} << (6 + cls_q));
          state_d = SWrite;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end
      // Find lowest inactive page.
      SClaim: begin
        if (objs_of(cls_q) == 6'd0 || 32'(pidx_q) >= Usable) begin
          st_d = StNoPage; state_d = SOut;
        end else if (!act_q[pcur]) begin
          best_d = pcur; pidx_d = '0; relrec_d = 4'd0;
          state_d = SRecRd;
        end else begin
          pidx_d = pidx_q + 1'b1;
        end
      end
      // Recency walk: claim bumps (relrec unused), retire decrements above relrec.
      SRecRd: begin
        if (32'(pidx_q) >= Usable) begin
          if (cmd_q == CmdAlloc) begin
            act_d[best_q] = 1'b1;
            // New page word: one object taken, recency newest.
            word_d = {cls_q, objs_of(cls_q) - 6'd1, 63'd1, 4'd0};
            oaddr_d = {4'(best_q), 12'd0} + Hdr;
            state_d = SWrite;
          end else begin
            act_d[best_q] = 1'b0;
            rel_d = 1'b1; state_d = SOut;
          end
        end else begin
          ra = pcur; state_d = SRecUpd;
        end
      end
      SRecUpd: begin
        ra = pcur;
        if (act_q[pcur] && rd_cls == cls_q && pcur != best_q) begin
          if (cmd_q == CmdAlloc) begin
            we = 1'b1; wd = {rd[WW-1:4], rd_rec + 4'd1};
          end else if (rd_rec > relrec_q) begin
            we = 1'b1; wd = {rd[WW-1:4], rd_rec - 4'd1};
          end
        end
        pidx_d = pidx_q + 1'b1;
        state_d = SRecRd;
      end
      SFreeChk: begin
        ra = PW'(fpage);
        best_d = PW'(fpage);
        cls_d = rd_cls;
        if (fofs < Hdr[11:0] || {4'd0, frel} >= flim) begin
          st_d = StRange; state_d = SOut;
        end else if (fmis) begin
          st_d = StMisalign; state_d = SOut;
        end else if (!rd_bm[fidx]) begin
          st_d = StDouble; state_d = SOut;
        end else if (rd_free + 6'd1 == objs_of(rd_cls)) begin
          we = 1'b1;
          wd = {rd_cls, rd_free + 6'd1, rd_bm & ~(63'd1 << fidx), rd_rec};
          relrec_d = rd_rec; pidx_d = '0; state_d = SRecRd;
        end else begin
          we = 1'b1;
          wd = {rd_cls, rd_free + 6'd1, rd_bm & ~(63'd1 << fidx), rd_rec};
          state_d = SOut;
        end
      end
      SWrite: begin
        we = 1'b1; ra = best_q; wd = word_q; state_d = SOut;
      end
      SOut: begin
        if (m_axis_tready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata  = {2'b0, rel_q, cls_q, (st_q == StOk) ? oaddr_q : 16'd0, st_q};

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_rel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rel_q |-> st_q == StOk) else $error("release with error");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule

[dv/three_class_slab_allocator_tb.sv]
// Testbench for the three-class slab allocator: random and directed requests.
`timescale 1ns / 1ps
module three_class_slab_allocator_tb;
  import tcsa_pkg::*;

  localparam int unsigned Pages  = NumPagesDef;
  localparam int unsigned Hdr    = HeaderBytesDef;
  localparam int unsigned WdLimit = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] addr;
    logic [1:0]  cls;
    logic        released;
  } slab_result_t;

  // Scoreboard: own copy of the page table and a queue of expected results.
  class slab_scoreboard;
    bit          active[Pages];
    bit [1:0]    cls[Pages];
    bit [5:0]    avail_cnt[Pages];
    bit [62:0]   bitmap[Pages];
    bit [3:0]    rank[Pages];
    int unsigned objs[3];
    slab_result_t pending_q[$];
    int errors;

    function new();
      objs[0] = objs_for(Hdr, 64);
      objs[1] = objs_for(Hdr, 128);
      objs[2] = objs_for(Hdr, 256);
      foreach (active[p]) active[p] = 0;
      errors = 0;
    endfunction

    function bit is_live(int unsigned a);
      int unsigned p;
      int unsigned off;
      int unsigned sz;
      p = a / PageBytes;
      off = a % PageBytes;
      if (p >= Pages || !active[p] || off < Hdr) return 0;
      sz = 64 << cls[p];
      if ((off - Hdr) % sz != 0 || (off - Hdr) / sz >= objs[cls[p]]) return 0;
      return bitmap[p][(off - Hdr) / sz];
    endfunction

    function slab_result_t allocate(int unsigned size);
      slab_result_t r;
      int best;
      int bit_i;
      int b;
      int unsigned c;
      int unsigned p;
      r = '0;
      if (size == 0 || size > 256) begin
        r.status = StBadSize;
        return r;
      end
      c = size <= 64 ? 0 : (size <= 128 ? 1 : 2);
      best = -1;
      bit_i = -1;
      for (p = 0; p < Pages; p++) begin
        if (!active[p] || cls[p] != c || avail_cnt[p] == 0) continue;
        b = -1;
        for (int i = 0; i < objs[c]; i++)
          if (!bitmap[p][i]) begin
            b = i;
            break;
          end
        if (b < 0) continue;
        if (best < 0 || rank[p] < rank[best]) begin
          best = p;
          bit_i = b;
        end
      end
      if (best < 0 && objs[c] > 0) begin
        for (p = 0; p < Pages; p++) if (!active[p]) break;
        if (p < Pages) begin
          for (int q = 0; q < Pages; q++)
            if (active[q] && cls[q] == c) rank[q] = rank[q] + 4'd1;
          active[p] = 1;
          cls[p] = 2'(c);
          avail_cnt[p] = 6'(objs[c]);
          bitmap[p] = '0;
          rank[p] = 0;
          best = p;
          bit_i = 0;
        end
      end
      r.cls = 2'(c);
      if (best < 0) begin
        r.status = StNoPage;
        return r;
      end
      bitmap[best][bit_i] = 1;
      avail_cnt[best] = avail_cnt[best] - 6'd1;
      r.status = StOk;
      r.addr = 16'(best * PageBytes + Hdr + bit_i * (64 << c));
      return r;
    endfunction

    function slab_result_t release_obj(int unsigned a);
      slab_result_t r;
      int unsigned p;
      int unsigned off;
      int unsigned sz;
      int unsigned idx;
      r = '0;
      p = a / PageBytes;
      off = a % PageBytes;
      if (p >= Pages || !active[p]) begin
        r.status = StNotSlab;
        return r;
      end
      r.cls = cls[p];
      sz = 64 << cls[p];
      if (off < Hdr || off - Hdr >= objs[cls[p]] * sz) begin
        r.status = StRange;
        return r;
      end
      if ((off - Hdr) % sz != 0) begin
        r.status = StMisalign;
        return r;
      end
      idx = (off - Hdr) / sz;
      if (!bitmap[p][idx]) begin
        r.status = StDouble;
        return r;
      end
      bitmap[p][idx] = 0;
      avail_cnt[p] = avail_cnt[p] + 6'd1;
      r.status = StOk;
      if (avail_cnt[p] == objs[cls[p]]) begin
        for (int q = 0; q < Pages; q++)
          if (q != p && active[q] && cls[q] == cls[p] && rank[q] > rank[p])
            rank[q] = rank[q] - 4'd1;
        active[p] = 0;
        r.released = 1;
      end
      return r;
    endfunction

    // Note an accepted request: predict its result and queue it.
    function void note_request(bit cmd, int unsigned size, int unsigned a);
      pending_q.push_back(cmd == CmdAlloc ? allocate(size) : release_obj(a));
    endfunction

    task report_error(string msg);
      errors++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Check one result against the oldest expectation.
    task check_result(logic [23:0] data);
      slab_result_t got;
      slab_result_t want;
      got.status = data[2:0];
      got.addr = data[18:3];
      got.cls = data[20:19];
      got.released = data[21];
      if (pending_q.size() == 0) begin
        report_error("result with no request pending");
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status)
        report_error($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.addr !== want.addr)
        report_error($sformatf("obj_addr %h, want %h", got.addr, want.addr));
      if (got.cls !== want.cls)
        report_error($sformatf("size_class %0d, want %0d", got.cls, want.cls));
      if (got.released !== want.released)
        report_error($sformatf("page_released %0d, want %0d", got.released,
                               want.released));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;

  slab_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles = 0;
  logic [15:0] live_q[$];

  always #6 clk_i = ~clk_i;

  three_class_slab_allocator u_top (.*);

  // Receiver: stall at random, check each accepted result.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one request and hold it until accepted, idling first at random.
  task automatic send_request(bit cmd, int unsigned size, int unsigned a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, 16'(a), 12'(size)};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, size & 32'hfff, a & 32'hffff);
  endtask

  // Free a live object the predictor knows about.
  task automatic free_live();
    int k;
    logic [15:0] a;
    k = $urandom_range(live_q.size() - 1);
    a = live_q[k];
    live_q.delete(k);
    send_request(CmdFree, 0, a);
  endtask

  task automatic random_phase(int n);
    int unsigned r;
    int unsigned sz;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        sz = ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(1, 256);
        send_request(CmdAlloc, sz, $urandom);
        if (sb.pending_q[$].status == StOk) live_q.push_back(sb.pending_q[$].addr);
      end else if (r < 85 && live_q.size() > 0) begin
        free_live();
      end else if (r < 92 && live_q.size() > 0) begin
        // free near a live object: misaligned, double free or exact
        send_request(CmdFree, $urandom_range(2), live_q[$urandom_range(live_q.size() - 1)]
                     + ($urandom_range(1) ? $urandom_range(1, 255) : 0));
        for (int j = live_q.size() - 1; j >= 0; j--)
          if (!sb.is_live(live_q[j])) live_q.delete(j);
      end else begin
        send_request(CmdFree, $urandom_range(4095), $urandom_range(65535));
        for (int j = live_q.size() - 1; j >= 0; j--)
          if (!sb.is_live(live_q[j])) live_q.delete(j);
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: size extremes, each class, error frees, then fill and drain.
    send_request(CmdAlloc, 0, 16'hffff);
    send_request(CmdAlloc, 4095, 0);
    send_request(CmdAlloc, 257, 0);
    send_request(CmdFree, 0, 0);
    send_request(CmdFree, 0, 16'hffff);
    send_request(CmdAlloc, 1, 0);
    send_request(CmdAlloc, 64, 0);
    send_request(CmdAlloc, 65, 0);
    send_request(CmdAlloc, 128, 0);
    send_request(CmdAlloc, 129, 0);
    send_request(CmdAlloc, 256, 0);
    send_request(CmdFree, 0, 16'h0010);           // inside header
    send_request(CmdFree, 0, 16'h0fff);           // past object area
    send_request(CmdFree, 0, 16'h0041);           // misaligned
    send_request(CmdFree, 0, 16'h0030 + 64 * 5);  // not in use
    send_request(CmdFree, 0, 16'h0030);
    send_request(CmdFree, 0, 16'h0030);           // double free
    send_request(CmdFree, 0, 16'h0070);           // retires page 0
    send_request(CmdFree, 0, 16'h1030);
    send_request(CmdFree, 0, 16'h10b0);           // retires page 1
    send_request(CmdFree, 0, 16'h2030);
    send_request(CmdFree, 0, 16'h3030);           // inactive page
    // exhaust the pool with 256-byte objects; the last requests find no page
    for (int i = 0; i < 16 * 15 + 1; i++) begin
      send_request(CmdAlloc, 200, 0);
      if (sb.pending_q[$].status == StOk) live_q.push_back(sb.pending_q[$].addr);
    end
    while (live_q.size() > 0) free_live();

    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 32) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 75 : 32) : 0;
      random_phase(340);
    end
    s_axis_tvalid <= 0;

    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
